/* sv/mau_pkg.sv */
// mau_pkg: shared types and constants for the modular arithmetic unit
// no dependencies
package mau_pkg;

  localparam int unsigned RES_W = 16;
  localparam int unsigned PROD_W = 32;
  localparam logic [RES_W-1:0] MOD_MIN = 16'd2;
  localparam logic [RES_W-1:0] MOD_MAX = 16'd46340;
  localparam logic [RES_W-1:0] TOT_MIN = 16'd1;

  typedef enum logic [2:0] {
    FN_ADD = 3'd0,
    FN_SUB = 3'd1,
    FN_NEG = 3'd2,
    FN_MUL = 3'd3,
    FN_DIV = 3'd4,
    FN_RCP = 3'd5,
    FN_EXP = 3'd6,
    FN_RSV = 3'd7
  } func_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_ZPZ      = 2'd1,
    ST_NOT_INV  = 2'd2,
    ST_MOST_NEG = 2'd3
  } status_t;

  typedef enum logic [0:0] {
    CFG_MODULUS = 1'b0,
    CFG_TOTIENT = 1'b1
  } cfg_idx_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_RED_A,
    S_RED_B,
    S_DISP,
    S_PW_STEP,
    S_PW_ACC,
    S_PW_SQ,
    S_INV_CHK,
    S_POST,
    S_FIN_MUL,
    S_DONE
  } state_t;

  // request to the shared reduction unit
  typedef struct packed {
    logic              go;
    logic [PROD_W-1:0] num;
  } red_req_t;

  typedef struct packed {
    logic             done;
    logic [RES_W-1:0] rem;
  } red_rsp_t;

endpackage

/* sv/modular_arithmetic_unit.sv */
// modular_arithmetic_unit: top level, sequencer around one shared multiplier
// and the iterative remainder unit; depends on mau_pkg, mau_cfg, mau_reduce
//
//  channel  ports                                   handshake
//  input    in_func in_first_operand in_second_...  start & !busy
//  result   out_value out_status                    out_strobe, one cycle
//  config   cfg_we cfg_index cfg_data               cfg_we, no wait
//
// every modular reduction runs through one bit-serial remainder unit and holds
// the sequencer for launch, 32 quotient bits and done; an item takes two
// entry reductions plus one per multiply.
// exponentiation costs up to 2 * EXP_WIDTH reductions, a negative exponent
// or divide/reciprocal adds up to 2 * 16 + 1 more for the inverse.
// reset is synchronous; busy stays high from start until the strobe.
// the receiver cannot stall: the result word is shown for one cycle.
module modular_arithmetic_unit #(
  parameter int unsigned EXP_WIDTH = 32
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  output logic                        busy,
  input  logic [2:0]                  in_func,
  input  logic [mau_pkg::RES_W-1:0]   in_first_operand,
  input  logic [mau_pkg::RES_W-1:0]   in_second_operand,
  input  logic signed [EXP_WIDTH-1:0] in_exponent,
  output logic                        out_strobe,
  output logic [mau_pkg::RES_W-1:0]   out_value,
  output logic [1:0]                  out_status,
  input  logic                        cfg_we,
  input  logic                        cfg_index,
  input  logic [mau_pkg::RES_W-1:0]   cfg_data
);

  localparam int unsigned RW = mau_pkg::RES_W;
  localparam int unsigned PW = mau_pkg::PROD_W;
  // power-run counter must hold both the exponent and totient - 1
  localparam int unsigned MAG_W = (EXP_WIDTH > RW) ? EXP_WIDTH : RW;
  localparam logic [EXP_WIDTH-1:0] TOP = {1'b1, {(EXP_WIDTH-1){1'b0}}};

  logic [RW-1:0] modulus, totient;
  mau_pkg::red_req_t req;
  mau_pkg::red_rsp_t rsp;

  mau_cfg u_cfg (
    .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_index(cfg_index),
    .cfg_data(cfg_data), .modulus(modulus), .totient(totient)
  );

  mau_reduce u_red (
    .clk(clk), .rst_n(rst_n), .modulus(modulus), .req(req), .rsp(rsp)
  );

  mau_pkg::state_t  st_r, st_nxt;
  mau_pkg::func_t   fn_r, fn_nxt;
  logic [RW-1:0]    a_r, a_nxt, b_r, b_nxt;
  logic [RW-1:0]    acc_r, acc_nxt, sq_r, sq_nxt;
  logic [MAG_W-1:0] mag_r, mag_nxt;
  logic [EXP_WIDTH-1:0] exp_r, exp_nxt;
  logic [EXP_WIDTH-1:0] neg_exp;
  logic             inv_r, inv_nxt;   // power run is an inverse
  logic             wait_r, wait_nxt; // reduction launched
  logic [1:0]       stat_r, stat_nxt;
  logic [RW-1:0]    val_r, val_nxt;
  logic             stb_r, stb_nxt;
  logic [RW-1:0]    one_mod;
  logic [RW:0]      addsum;
  logic [RW-1:0]    inv_src;

  // single shared multiplier, operands picked by state
  logic [RW-1:0] mul_x, mul_y;
  logic [PW-1:0] prod;
  assign prod = mul_x * mul_y;

  assign one_mod = (modulus == 16'd1) ? '0 : 16'd1;
  assign inv_src = (fn_r == mau_pkg::FN_DIV) ? b_r : a_r;
  // exponent magnitude at its own width
  assign neg_exp = -exp_r;

  // multiplier operands picked by state, acc times sq by default
  always_comb begin
    mul_x = acc_r;
    mul_y = sq_r;
    case (st_r)
      mau_pkg::S_PW_SQ:   begin mul_x = sq_r;    mul_y = sq_r;  end
      mau_pkg::S_INV_CHK: begin mul_x = inv_src; mul_y = acc_r; end
      mau_pkg::S_FIN_MUL: begin
        mul_x = a_r;
        mul_y = (fn_r == mau_pkg::FN_MUL) ? b_r : acc_r;
      end
      default: ;
    endcase
  end

  always_comb begin
    st_nxt = st_r;
    case (st_r)
      mau_pkg::S_IDLE:    if (start) st_nxt = mau_pkg::S_RED_A;
      mau_pkg::S_RED_A:   if (wait_r && rsp.done) st_nxt = mau_pkg::S_RED_B;
      mau_pkg::S_RED_B:   if (wait_r && rsp.done) st_nxt = mau_pkg::S_DISP;
      mau_pkg::S_DISP: begin
        st_nxt = mau_pkg::S_DONE;
        case (fn_r)
          mau_pkg::FN_MUL: st_nxt = mau_pkg::S_FIN_MUL;
          mau_pkg::FN_DIV: if (b_r != '0 && modulus != 16'd2) st_nxt = mau_pkg::S_PW_STEP;
                           else if (b_r != '0) st_nxt = mau_pkg::S_FIN_MUL;
          mau_pkg::FN_RCP: if (a_r != '0 && modulus != 16'd2) st_nxt = mau_pkg::S_PW_STEP;
          mau_pkg::FN_EXP: begin
            if (exp_r == '0) st_nxt = mau_pkg::S_DONE;
            else if (exp_r[EXP_WIDTH-1]) begin
              if (a_r != '0 && exp_r != TOP && modulus != 16'd2)
                st_nxt = mau_pkg::S_PW_STEP;
              else if (a_r != '0 && exp_r != TOP) st_nxt = mau_pkg::S_PW_STEP;
            end else st_nxt = mau_pkg::S_PW_STEP;
          end
          default: ;
        endcase
      end
      mau_pkg::S_PW_STEP: begin
        if (mag_r == '0) st_nxt = inv_r ? mau_pkg::S_INV_CHK : mau_pkg::S_DONE;
        else if (mag_r[0]) st_nxt = mau_pkg::S_PW_ACC;
        else st_nxt = mau_pkg::S_PW_SQ;
      end
      mau_pkg::S_PW_ACC:  if (wait_r && rsp.done) st_nxt = mau_pkg::S_PW_SQ;
      mau_pkg::S_PW_SQ:   if (wait_r && rsp.done) st_nxt = mau_pkg::S_PW_STEP;
      mau_pkg::S_INV_CHK: if (wait_r && rsp.done) st_nxt = mau_pkg::S_POST;
      mau_pkg::S_POST: begin
        st_nxt = mau_pkg::S_DONE;
        if (stat_r == mau_pkg::ST_OK) begin
          if (fn_r == mau_pkg::FN_DIV) st_nxt = mau_pkg::S_FIN_MUL;
          else if (fn_r == mau_pkg::FN_EXP) st_nxt = mau_pkg::S_PW_STEP;
        end
      end
      mau_pkg::S_FIN_MUL: if (wait_r && rsp.done) st_nxt = mau_pkg::S_DONE;
      mau_pkg::S_DONE:    st_nxt = mau_pkg::S_IDLE;
      default:            st_nxt = mau_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    fn_nxt   = fn_r;
    a_nxt    = a_r;
    b_nxt    = b_r;
    acc_nxt  = acc_r;
    sq_nxt   = sq_r;
    mag_nxt  = mag_r;
    exp_nxt  = exp_r;
    inv_nxt  = inv_r;
    wait_nxt = wait_r;
    stat_nxt = stat_r;
    val_nxt  = val_r;
    stb_nxt  = 1'b0;
    req.go   = 1'b0;
    req.num  = prod;
    addsum   = '0;
    case (st_r)
      mau_pkg::S_IDLE: begin
        if (start) begin
          fn_nxt   = mau_pkg::func_t'(in_func);
          a_nxt    = in_first_operand;
          b_nxt    = in_second_operand;
          exp_nxt  = in_exponent;
          stat_nxt = mau_pkg::ST_OK;
          val_nxt  = '0;
          inv_nxt  = 1'b0;
          wait_nxt = 1'b0;
        end
      end
      mau_pkg::S_RED_A, mau_pkg::S_RED_B: begin
        req.num = {16'd0, (st_r == mau_pkg::S_RED_A) ? a_r : b_r};
        if (!wait_r) begin
          req.go = 1'b1; wait_nxt = 1'b1;
        end else if (rsp.done) begin
          wait_nxt = 1'b0;
          if (st_r == mau_pkg::S_RED_A) a_nxt = rsp.rem;
          else b_nxt = rsp.rem;
        end
      end
      mau_pkg::S_DISP: begin
        acc_nxt = one_mod;
        case (fn_r)
          mau_pkg::FN_ADD: begin
            addsum = {1'b0, a_r} + {1'b0, b_r};
            val_nxt = (addsum >= {1'b0, modulus}) ? RW'(addsum - {1'b0, modulus})
                                                  : addsum[RW-1:0];
          end
          mau_pkg::FN_SUB: val_nxt = (a_r >= b_r) ? a_r - b_r : RW'(modulus + a_r - b_r);
          mau_pkg::FN_NEG: val_nxt = (a_r == '0) ? '0 : modulus - a_r;
          mau_pkg::FN_DIV, mau_pkg::FN_RCP: begin
            if (inv_src == '0) stat_nxt = mau_pkg::ST_NOT_INV;
            else if (modulus == 16'd2) begin
              acc_nxt = inv_src; val_nxt = inv_src;
            end else begin
              sq_nxt = inv_src; inv_nxt = 1'b1;
              mag_nxt = MAG_W'(totient - 1'b1);
            end
          end
          mau_pkg::FN_EXP: begin
            if (exp_r == '0) begin
              if (a_r == '0) stat_nxt = mau_pkg::ST_ZPZ;
              else val_nxt = one_mod;
            end else if (exp_r[EXP_WIDTH-1]) begin
              if (a_r == '0) stat_nxt = mau_pkg::ST_NOT_INV;
              else if (exp_r == TOP) stat_nxt = mau_pkg::ST_MOST_NEG;
              else if (modulus == 16'd2) begin
                // inverse of 1 is 1, go straight to the power run
                sq_nxt = a_r; mag_nxt = MAG_W'(neg_exp);
              end else begin
                sq_nxt = a_r; inv_nxt = 1'b1;
                mag_nxt = MAG_W'(totient - 1'b1);
              end
            end else begin
              sq_nxt = a_r; mag_nxt = MAG_W'(exp_r);
            end
          end
          default: val_nxt = '0;
        endcase
      end
      mau_pkg::S_PW_STEP: if (mag_r == '0 && !inv_r) val_nxt = acc_r;
      mau_pkg::S_PW_ACC, mau_pkg::S_PW_SQ,
      mau_pkg::S_INV_CHK, mau_pkg::S_FIN_MUL: begin
        if (!wait_r) begin
          req.go = 1'b1; wait_nxt = 1'b1;
        end else if (rsp.done) begin
          wait_nxt = 1'b0;
          case (st_r)
            mau_pkg::S_PW_ACC: acc_nxt = rsp.rem;
            mau_pkg::S_PW_SQ: begin
              sq_nxt = rsp.rem; mag_nxt = mag_r >> 1;
            end
            mau_pkg::S_INV_CHK: begin
              inv_nxt = 1'b0;
              if (rsp.rem != 16'd1) stat_nxt = mau_pkg::ST_NOT_INV;
              else if (fn_r == mau_pkg::FN_RCP) val_nxt = acc_r;
            end
            default: val_nxt = rsp.rem;
          endcase
        end
      end
      mau_pkg::S_POST: begin
        // inverse in acc; set up the power run for a negative exponent
        if (fn_r == mau_pkg::FN_EXP) begin
          sq_nxt = acc_r; acc_nxt = one_mod; mag_nxt = MAG_W'(neg_exp);
        end
      end
      mau_pkg::S_DONE: begin
        stb_nxt = 1'b1;
        if (stat_r != mau_pkg::ST_OK) val_nxt = '0;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r   <= mau_pkg::S_IDLE;
      stb_r  <= 1'b0;
      wait_r <= 1'b0;
    end else begin
      st_r   <= st_nxt;
      stb_r  <= stb_nxt;
      wait_r <= wait_nxt;
    end
    fn_r   <= fn_nxt;
    a_r    <= a_nxt;
    b_r    <= b_nxt;
    acc_r  <= acc_nxt;
    sq_r   <= sq_nxt;
    mag_r  <= mag_nxt;
    exp_r  <= exp_nxt;
    inv_r  <= inv_nxt;
    stat_r <= stat_nxt;
    val_r  <= val_nxt;
  end

  assign busy       = (st_r != mau_pkg::S_IDLE);
  assign out_strobe = stb_r;
  assign out_value  = val_r;
  assign out_status = stat_r;

  // strobe only follows the done state
  a_stb_after_done: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> $past(st_r) == mau_pkg::S_DONE) else $error("stray strobe");

  // an error word carries a zero value
  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe && out_status != mau_pkg::ST_OK |-> out_value == '0) else $error("error value");

  // an ok word is a residue
  a_residue: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe && out_status == mau_pkg::ST_OK |-> out_value < modulus) else $error("not reduced");

  // a launch is never directly followed by another launch
  a_no_relaunch: assert property (@(posedge clk) disable iff (!rst_n)
    req.go |=> !req.go) else $error("double launch");

endmodule

/* sv/mau_reduce.sv */
// mau_reduce: iterative restoring remainder, one quotient bit per cycle
// depends on mau_pkg
module mau_reduce (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic [mau_pkg::RES_W-1:0] modulus,
  input  mau_pkg::red_req_t         req,
  output mau_pkg::red_rsp_t         rsp
);

  localparam int unsigned CNT_W = $clog2(mau_pkg::PROD_W + 1);

  logic [mau_pkg::PROD_W-1:0] num_r, num_nxt;
  logic [mau_pkg::RES_W:0]    rem_r, rem_nxt;
  logic [CNT_W-1:0]           cnt_r, cnt_nxt;
  logic                       busy_r, busy_nxt;
  logic                       done_r, done_nxt;
  logic [mau_pkg::RES_W+1:0]  trial;
  logic [mau_pkg::RES_W+1:0]  diff;

  always_comb begin
    num_nxt  = num_r;
    rem_nxt  = rem_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    trial    = {rem_r, num_r[mau_pkg::PROD_W-1]};
    diff     = trial - {2'b00, modulus};
    if (req.go) begin
      num_nxt  = req.num;
      rem_nxt  = '0;
      cnt_nxt  = CNT_W'(mau_pkg::PROD_W);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      num_nxt = {num_r[mau_pkg::PROD_W-2:0], 1'b0};
      // remainder stays below modulus so fits RES_W+1 bits
      if (!diff[mau_pkg::RES_W+1]) begin
        rem_nxt = diff[mau_pkg::RES_W:0];
      end else begin
        rem_nxt = trial[mau_pkg::RES_W:0];
      end
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == CNT_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    num_r <= num_nxt;
    rem_r <= rem_nxt;
  end

  assign rsp.done = done_r;
  assign rsp.rem  = rem_r[mau_pkg::RES_W-1:0];

endmodule

/* sv/mau_cfg.sv */
// mau_cfg: modulus and totient registers with saturating writes
// depends on mau_pkg
module mau_cfg (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      cfg_we,
  input  logic                      cfg_index,
  input  logic [mau_pkg::RES_W-1:0] cfg_data,
  output logic [mau_pkg::RES_W-1:0] modulus,
  output logic [mau_pkg::RES_W-1:0] totient
);

  logic [mau_pkg::RES_W-1:0] mod_r, mod_nxt;
  logic [mau_pkg::RES_W-1:0] tot_r, tot_nxt;
  logic [mau_pkg::RES_W-1:0] sat_hi;

  always_comb begin
    mod_nxt = mod_r;
    tot_nxt = tot_r;
    sat_hi  = (cfg_data > mau_pkg::MOD_MAX) ? mau_pkg::MOD_MAX : cfg_data;
    if (cfg_we) begin
      case (mau_pkg::cfg_idx_t'(cfg_index))
        mau_pkg::CFG_MODULUS: mod_nxt = (sat_hi < mau_pkg::MOD_MIN) ? mau_pkg::MOD_MIN : sat_hi;
        mau_pkg::CFG_TOTIENT: tot_nxt = (sat_hi < mau_pkg::TOT_MIN) ? mau_pkg::TOT_MIN : sat_hi;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mod_r <= mau_pkg::MOD_MIN;
      tot_r <= mau_pkg::TOT_MIN;
    end else begin
      mod_r <= mod_nxt;
      tot_r <= tot_nxt;
    end
  end

  assign modulus = mod_r;
  assign totient = tot_r;

endmodule
